/* design/sorted_point_table_window_assert.svh */
// ---------------------------------------------------------------------------
// assertion macros shared by the sorted point table
// ---------------------------------------------------------------------------
`ifndef SORTED_POINT_TABLE_WINDOW_ASSERT_SVH
`define SORTED_POINT_TABLE_WINDOW_ASSERT_SVH

// property must hold on every clock edge outside reset
`define SPTW_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// antecedent implies consequent in the same cycle
`define SPTW_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

/* design/sptw_pkg.sv */
// ---------------------------------------------------------------------------
// sptw_pkg
// types and codes shared by the sorted point table modules
// ---------------------------------------------------------------------------
package sptw_pkg;

   localparam logic ACT_INSERT = 1'b0;
   localparam logic ACT_QUERY  = 1'b1;

   localparam logic [1:0] ST_INSERTED = 2'd0;
   localparam logic [1:0] ST_FULL     = 2'd1;
   localparam logic [1:0] ST_VALID    = 2'd2;
   localparam logic [1:0] ST_EMPTY    = 2'd3;

   localparam int IDX_W = 8;
   localparam int CNT_W = 9;

endpackage

/* design/sptw_front.sv */
// ---------------------------------------------------------------------------
// sptw_front
// two-entry request queue between the port and the engine
// ---------------------------------------------------------------------------
module sptw_front #(
   parameter int VW = 32
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   output logic            in_ready,
   input  logic [3*VW+1:0] in_data,
   output logic            out_valid,
   input  logic            out_ready,
   output logic [3*VW+1:0] out_data
);
   import sptw_pkg::*;

   logic [3*VW+1:0] q_ff [2];
   logic [3*VW+1:0] q_in [2];
   logic [1:0]      cnt_ff, cnt_in;
   logic            push, pop;

   assign in_ready  = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_data  = q_ff[0];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      q_in[0] = q_ff[0];
      q_in[1] = q_ff[1];
      cnt_in  = cnt_ff;
      if (pop) begin
         q_in[0] = q_ff[1];
         cnt_in  = cnt_in - 2'd1;
      end
      if (push) begin
         if (cnt_in == 2'd0) q_in[0] = in_data;
         else q_in[1] = in_data;
         cnt_in = cnt_in + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      q_ff[0] <= q_in[0];
      q_ff[1] <= q_in[1];
      if (reset) cnt_ff <= 2'd0;
      else cnt_ff <= cnt_in;
   end

`include "sorted_point_table_window_assert.svh"
   `SPTW_ASSERT(a_cnt_range, cnt_ff != 2'd3, "queue fill out of range")
   `SPTW_IMPLY(a_no_push_full, cnt_ff == 2'd2, !push, "push into full queue")
   `SPTW_ASSERT(a_pop_nonempty, !pop || cnt_ff != 2'd0, "pop from empty queue")
endmodule

/* design/sptw_engine.sv */
// ---------------------------------------------------------------------------
// sptw_engine
// table memories and sequencer for insert shifts and window scans
// ---------------------------------------------------------------------------
module sptw_engine #(
   parameter int CAP = 256,
   parameter int VW  = 32
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            cmd_valid,
   output logic            cmd_ready,
   input  logic [3*VW+1:0] cmd_data,
   output logic            res_valid,
   input  logic            res_ready,
   output logic [1:0]      res_status,
   output logic [sptw_pkg::CNT_W-1:0] res_count,
   output logic [sptw_pkg::IDX_W-1:0] res_ilo,
   output logic [sptw_pkg::IDX_W-1:0] res_ihi,
   output logic [VW-1:0]   res_fx,
   output logic [VW-1:0]   res_lx,
   output logic [VW-1:0]   res_mny,
   output logic [VW-1:0]   res_mxy,
   output logic            res_refresh
);
   import sptw_pkg::*;

   localparam int AW = (CAP > 1) ? $clog2(CAP) : 1;
   localparam int NW = $clog2(CAP + 1);

   typedef enum logic [2:0] {
      S_IDLE, S_CNT, S_SHIFT, S_WRITE, S_SCAN, S_ENDS, S_DONE
   } state_type;

   logic [VW-1:0] xmem [CAP];
   logic [VW-1:0] ymem [CAP];

   state_type      state_ff;
   logic [NW-1:0]  n_ff;
   logic [NW-1:0]  i_ff;      // scan / shift pointer
   logic           rd_ok_ff;  // read data valid for previous i
   logic [NW-1:0]  ridx_ff;
   logic [VW-1:0]  xr_ff, yr_ff;
   logic [NW-1:0]  clo_ff, chi_ff;
   logic [NW-1:0]  lo_ff, hi_ff;
   logic           act_ff, last_ff;
   logic [VW-1:0]  px_ff, py_ff, dl_ff, dh_ff;
   logic [VW-1:0]  mny_ff, mxy_ff, fx_ff, lx_ff;
   logic           seen_ff;
   logic [1:0]     st_ff;
   logic           valid_ff;
   logic [NW-1:0]  k_ff;
   logic [AW-1:0]  rd_addr;
   logic           rd_en;
   logic           wr_en;
   logic [AW-1:0]  wr_addr;
   logic [VW-1:0]  wx, wy;

   function automatic logic lt(input logic [VW-1:0] a, input logic [VW-1:0] b);
      lt = $signed(a) < $signed(b);
   endfunction

   assign cmd_ready = (state_ff == S_IDLE) && !valid_ff;
   assign res_valid = valid_ff;
   assign res_status = st_ff;
   assign res_count  = CNT_W'(n_ff);
   assign res_ilo    = IDX_W'(lo_ff);
   assign res_ihi    = IDX_W'(hi_ff);
   assign res_fx     = fx_ff;
   assign res_lx     = lx_ff;
   assign res_mny    = mny_ff;
   assign res_mxy    = mxy_ff;
   assign res_refresh = last_ff && (act_ff == ACT_INSERT);

   // read port address
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = AW'(i_ff);
      unique case (state_ff)
         S_CNT, S_SCAN: rd_en = (i_ff < n_ff);
         S_SHIFT:       begin rd_en = (i_ff > k_ff); rd_addr = AW'(i_ff - NW'(1)); end
         S_ENDS:        begin rd_en = 1'b1; rd_addr = (i_ff == '0) ? '0 : AW'(n_ff - NW'(1)); end
         default:       rd_en = 1'b0;
      endcase
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = AW'(i_ff);
      wx      = px_ff;
      wy      = py_ff;
      if (state_ff == S_SHIFT && rd_ok_ff) begin
         wr_en   = 1'b1;
         wr_addr = AW'(ridx_ff + NW'(1));
         wx      = xr_ff;
         wy      = yr_ff;
      end else if (state_ff == S_WRITE) begin
         wr_en   = 1'b1;
         wr_addr = AW'(k_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         xr_ff <= xmem[rd_addr];
         yr_ff <= ymem[rd_addr];
      end
      if (wr_en) begin
         xmem[wr_addr] <= wx;
         ymem[wr_addr] <= wy;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         n_ff     <= '0;
         valid_ff <= 1'b0;
         rd_ok_ff <= 1'b0;
      end else begin
         if (valid_ff && res_ready) valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: if (cmd_valid && cmd_ready) begin
               act_ff  <= cmd_data[0];
               px_ff   <= cmd_data[VW:1];
               py_ff   <= cmd_data[2*VW:VW+1];
               last_ff <= cmd_data[2*VW+1];
               dl_ff   <= cmd_data[VW:1];
               dh_ff   <= cmd_data[2*VW:VW+1];
               i_ff <= '0; clo_ff <= '0; chi_ff <= '0;
               rd_ok_ff <= 1'b0;
               seen_ff  <= 1'b0;
               lo_ff <= '0; hi_ff <= '0; mny_ff <= '0; mxy_ff <= '0;
               fx_ff <= '0; lx_ff <= '0;
               if (cmd_data[0] == ACT_INSERT && n_ff == NW'(CAP)) begin
                  st_ff <= ST_FULL;
                  state_ff <= S_ENDS;
               end else state_ff <= S_CNT;
            end
            S_CNT: begin
               // one entry per cycle: query counts x below both bounds,
               // insert counts x below and x not above the new x
               rd_ok_ff <= (i_ff < n_ff);
               ridx_ff  <= i_ff;
               if (rd_ok_ff) begin
                  if (lt(xr_ff, act_ff ? dl_ff : px_ff)) clo_ff <= clo_ff + NW'(1);
                  if ((act_ff == ACT_QUERY) ? lt(xr_ff, dh_ff) : !lt(px_ff, xr_ff))
                     chi_ff <= chi_ff + NW'(1);
               end
               if (!(i_ff < n_ff) && !rd_ok_ff) begin
                  if (act_ff == ACT_INSERT) begin
                     // append when no entry lies above the new x
                     k_ff <= (chi_ff == n_ff) ? n_ff : clo_ff;
                     i_ff <= n_ff; state_ff <= S_SHIFT;
                  end else if (n_ff == '0) begin
                     st_ff <= ST_EMPTY; state_ff <= S_DONE;
                  end else begin
                     lo_ff <= (clo_ff == '0) ? '0 : clo_ff - NW'(1);
                     hi_ff <= (chi_ff >= n_ff) ? n_ff - NW'(1) : chi_ff;
                     i_ff  <= (clo_ff == '0) ? '0 : clo_ff - NW'(1);
                     state_ff <= S_SCAN;
                  end
               end else if (i_ff < n_ff) i_ff <= i_ff + NW'(1);
            end
            S_SHIFT: begin
               // read entry i-1, write it at i, from the top down
               rd_ok_ff <= (i_ff > k_ff);
               ridx_ff  <= i_ff - NW'(1);
               if (i_ff > k_ff) i_ff <= i_ff - NW'(1);
               else if (!rd_ok_ff) state_ff <= S_WRITE;
            end
            S_WRITE: begin
               n_ff  <= n_ff + NW'(1);
               st_ff <= ST_INSERTED;
               i_ff  <= '0;
               state_ff <= S_ENDS;
            end
            S_SCAN: begin
               rd_ok_ff <= (i_ff <= hi_ff) && (lo_ff <= hi_ff);
               if (rd_ok_ff) begin
                  if (!seen_ff || lt(yr_ff, mny_ff)) mny_ff <= yr_ff;
                  if (!seen_ff || lt(mxy_ff, yr_ff)) mxy_ff <= yr_ff;
                  seen_ff <= 1'b1;
               end
               if ((i_ff <= hi_ff) && (lo_ff <= hi_ff)) i_ff <= i_ff + NW'(1);
               else if (!rd_ok_ff) begin
                  st_ff <= (lo_ff <= hi_ff) ? ST_VALID : ST_EMPTY;
                  i_ff  <= '0;
                  state_ff <= S_ENDS;
               end
            end
            S_ENDS: begin
               // two reads: entry zero then last entry
               if (n_ff == '0) begin
                  fx_ff <= '0; lx_ff <= '0; state_ff <= S_DONE;
               end else begin
                  i_ff <= i_ff + NW'(1);
                  if (!rd_ok_ff) rd_ok_ff <= 1'b1;
                  else if (i_ff == NW'(1)) fx_ff <= xr_ff;
                  else begin
                     lx_ff <= xr_ff;
                     rd_ok_ff <= 1'b0;
                     state_ff <= S_DONE;
                  end
               end
            end
            S_DONE: if (!valid_ff) begin
               valid_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

`include "sorted_point_table_window_assert.svh"
   `SPTW_ASSERT(a_count_cap, n_ff <= NW'(CAP), "entry count above capacity")
   `SPTW_IMPLY(a_busy_no_take, state_ff != S_IDLE, !cmd_ready, "command taken while busy")
   `SPTW_IMPLY(a_full_status, valid_ff && st_ff == ST_FULL, n_ff == NW'(CAP),
      "drop reported with room left")
endmodule

/* design/sorted_point_table_window.sv */
// ---------------------------------------------------------------------------
// sorted_point_table_window
// table of (x, y) points kept sorted by x, with insert and window query
// ---------------------------------------------------------------------------
// channel  direction  payload
// req_     in         action (tuser), x, y, domain bounds, last
// rsp_     out        status (tuser), count, indices, end x, y range, refresh
//
// an insert counts and then shifts the n entries, a query counts them and then scans its
// window of w entries, through one read and one write port of the point memories
// reset is synchronous and empties the table; memories are not cleared
// a two-request queue lets requests arrive while the engine works
// a result waits in its register until rsp_tready
// ---------------------------------------------------------------------------
module sorted_point_table_window #(
   parameter int CAPACITY    = 256,
   parameter int VALUE_WIDTH = 32
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // point_x, point_y, domain_low, domain_high
   input  logic [((4*VALUE_WIDTH+7)/8)*8-1:0] req_tdata,
   // last_in_batch
   input  logic req_tlast,
   // action
   input  logic [0:0] req_tuser,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // entry_count, index_low, index_high, first_x, last_x, min_y, max_y, padding
   output logic [((4*VALUE_WIDTH+25+7)/8)*8-1:0] rsp_tdata,
   // needs_refresh
   output logic rsp_tlast,
   // status
   output logic [1:0] rsp_tuser
);
   import sptw_pkg::*;

   localparam int VW = VALUE_WIDTH;
   localparam int DW = ((4*VW+25+7)/8)*8;

   logic [3*VW+1:0] in_pack, q_data;
   logic q_valid, q_ready;
   logic [CNT_W-1:0] cnt;
   logic [IDX_W-1:0] ilo, ihi;
   logic [VW-1:0] fx, lx, mny, mxy;
   logic [VW:1] sel_a, sel_b;

   // insert uses point fields, query the domain bounds in the same slots
   assign sel_a = req_tuser[0] ? req_tdata[3*VW-1:2*VW] : req_tdata[VW-1:0];
   assign sel_b = req_tuser[0] ? req_tdata[4*VW-1:3*VW] : req_tdata[2*VW-1:VW];
   assign in_pack = {req_tlast, sel_b, sel_a, req_tuser[0]};

   sptw_front #(.VW(VW)) u_front (
      .clock, .reset,
      .in_valid(req_tvalid), .in_ready(req_tready), .in_data(in_pack),
      .out_valid(q_valid), .out_ready(q_ready), .out_data(q_data)
   );

   sptw_engine #(.CAP(CAPACITY), .VW(VW)) u_engine (
      .clock, .reset,
      .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd_data(q_data),
      .res_valid(rsp_tvalid), .res_ready(rsp_tready),
      .res_status(rsp_tuser), .res_count(cnt), .res_ilo(ilo), .res_ihi(ihi),
      .res_fx(fx), .res_lx(lx), .res_mny(mny), .res_mxy(mxy),
      .res_refresh(rsp_tlast)
   );

   assign rsp_tdata = DW'({mxy, mny, lx, fx, ihi, ilo, cnt});
endmodule
